### src/hcb_pkg.sv
// Shared definitions for the mod-26 Hill cipher block: constants, the
// control bundle of the shared multiply-accumulate unit and the mod-26 reducer.
// No dependencies.
package hcb_pkg;

  localparam int MAX_SIZE = 3;
  localparam int MODULUS  = 26;
  localparam int LETTER_A = 65;

  // accumulator width: largest value is 3 * 25 * 25 = 1875
  localparam int ACC_W = 11;

  // cofactor terms lie in -625..625; this offset keeps the sum non-negative
  // and is itself a multiple of 26
  localparam logic [ACC_W-1:0] COF_BIAS = 11'd650;

  // floor(2^16 / 26) rounded down, so the quotient estimate never overshoots
  localparam int RECIP = 2520;

  typedef struct packed {
    logic en;     // update the accumulator
    logic first;  // start a new sum instead of adding to the old one
    logic bias;   // start value is COF_BIAS instead of zero
    logic sub;    // subtract the product
  } mac_ctl_t;

  // x mod 26 by reciprocal multiply; one correction step covers the error
  function automatic logic [4:0] mod26_f(input logic [ACC_W-1:0] x);
    logic [ACC_W+11:0] prod;
    logic [ACC_W-5:0]  q;
    logic [ACC_W-1:0]  r;
    prod = {12'd0, x} * (ACC_W + 12)'(RECIP);
    q    = prod[ACC_W+11:16];
    r    = x - ACC_W'(q) * ACC_W'(MODULUS);
    if (r >= ACC_W'(MODULUS)) begin
      r = r - ACC_W'(MODULUS);
    end
    return r[4:0];
  endfunction

endpackage

### src/hill_cipher_block.sv
// Hill cipher over 26 letters: letters in, enciphered or deciphered letters out.
// Encrypt: a full block of n letters holds the input off while it runs n MAC steps and one
// reduce per row. Decrypt first runs a key inversion pass (cofactor, determinant and scaling
// steps); a key with no inverse gives its error result after the determinant. Output stalls
// lengthen both passes, as the reduce and error states wait for the output to be free.
// A letter that does not complete a block is stored while the input stays ready.
// Reset (rst_n low at a clock edge) empties the block and restores key_size 2, encrypt.
module hill_cipher_block (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] text_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [6:0] letter_out, [7] zero
  output logic        out_tlast,   // last_of_block
  output logic        out_tuser,   // key_error
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_wdata
);
  import hcb_pkg::*;

  localparam logic [2:0] CFG_KEY_SIZE  = 3'd0;
  localparam logic [2:0] CFG_DECRYPT   = 3'd1;
  localparam logic [2:0] CFG_ROW_FIRST = 3'd2;
  localparam logic [2:0] CFG_ROW_SEC   = 3'd3;
  localparam logic [2:0] CFG_ROW_THIRD = 3'd4;

  localparam logic [4:0] MOD5 = 5'(MODULUS);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_COF  = 10'b0000000010,
    ST_CRED = 10'b0000000100,
    ST_DET  = 10'b0000001000,
    ST_DRED = 10'b0000010000,
    ST_SCL  = 10'b0000100000,
    ST_SRED = 10'b0001000000,
    ST_MUL  = 10'b0010000000,
    ST_MRED = 10'b0100000000,
    ST_ERR  = 10'b1000000000
  } state_t;

  function automatic logic [4:0] key_f(input logic [14:0] r0, input logic [14:0] r1,
                                       input logic [14:0] r2, input logic n3,
                                       input logic [1:0] row, input logic [1:0] col);
    logic [14:0] bits;
    logic [4:0]  raw;
    logic [4:0]  v;
    case (row)
      2'd0:    bits = r0;
      2'd1:    bits = r1;
      default: bits = r2;
    endcase
    case (col)
      2'd0:    raw = bits[4:0];
      2'd1:    raw = bits[9:5];
      default: raw = bits[14:10];
    endcase
    v = (raw >= MOD5) ? raw - MOD5 : raw;
    // 2x2 key embedded in a 3x3 with a unit corner: same det and same 2x2 inverse
    if (!n3 && (row == 2'd2 || col == 2'd2)) begin
      v = (row == col) ? 5'd1 : 5'd0;
    end
    return v;
  endfunction

  function automatic logic [4:0] inv26_f(input logic [4:0] d);
    logic [4:0] v;
    case (d)
      5'd1:    v = 5'd1;
      5'd3:    v = 5'd9;
      5'd5:    v = 5'd21;
      5'd7:    v = 5'd15;
      5'd9:    v = 5'd3;
      5'd11:   v = 5'd19;
      5'd15:   v = 5'd7;
      5'd17:   v = 5'd23;
      5'd19:   v = 5'd11;
      5'd21:   v = 5'd5;
      5'd23:   v = 5'd17;
      5'd25:   v = 5'd25;
      default: v = 5'd0;
    endcase
    return v;
  endfunction

  // the two indexes other than x, in ascending order
  function automatic logic [1:0] oth_lo(input logic [1:0] x);
    return (x == 2'd0) ? 2'd1 : 2'd0;
  endfunction

  function automatic logic [1:0] oth_hi(input logic [1:0] x);
    return (x == 2'd2) ? 2'd1 : 2'd2;
  endfunction

  state_t      state_r, state_nxt;
  logic [1:0]  key_size_r;
  logic        decrypt_r;
  logic [14:0] key_row_first_r, key_row_second_r, key_row_third_r;
  logic [1:0]  fill_r, fill_nxt;
  logic [1:0]  i_r, i_nxt;
  logic [1:0]  j_r, j_nxt;
  logic        s_r, s_nxt;
  logic [4:0]  blk_r [MAX_SIZE];
  logic [4:0]  cof_r [MAX_SIZE*MAX_SIZE];
  logic [4:0]  dinv_r;
  logic        out_valid_r, out_valid_nxt;
  logic [6:0]  out_letter_r;
  logic        out_last_r;
  logic        out_err_r;

  logic        n3;
  logic [1:0]  last_idx;
  logic        in_acc;
  logic [1:0]  fill_inc;
  logic        blk_full;
  logic [4:0]  residue;
  logic        out_free;

  logic [1:0]  ka_row, ka_col, kb_row, kb_col;
  logic [1:0]  cof_row, cof_col;
  logic [3:0]  cof_addr;
  logic [4:0]  key_a, key_b, cof_rd, blk_rd;
  logic        pick_b;

  mac_ctl_t    mac_ctl;
  logic [4:0]  op_a, op_b, mac_res;

  logic        out_ld;
  logic [6:0]  ld_letter;
  logic        ld_last, ld_err;
  logic        cof_we, dinv_we;

  assign n3        = (key_size_r == 2'd3);
  assign last_idx  = n3 ? 2'd2 : 2'd1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign fill_inc  = fill_r + 2'd1;
  assign blk_full  = (fill_inc > last_idx);
  // (byte - 65) mod 26 taken non-negative equals (byte + 195) mod 26
  assign residue   = mod26_f({3'd0, in_tdata} + 11'd195);
  assign out_free  = !out_valid_r || out_tready;

  // operand addressing
  always_comb begin
    pick_b  = (i_r[0] ^ j_r[0]) ^ s_r;
    ka_row  = i_r;
    ka_col  = j_r;
    kb_row  = i_r;
    kb_col  = j_r;
    cof_row = i_r;
    cof_col = j_r;
    unique case (state_r)
      ST_COF: begin
        // positive product first so the biased sum never goes negative
        ka_row = oth_lo(i_r);
        kb_row = oth_hi(i_r);
        ka_col = pick_b ? oth_hi(j_r) : oth_lo(j_r);
        kb_col = pick_b ? oth_lo(j_r) : oth_hi(j_r);
      end
      ST_DET: begin
        ka_row  = 2'd0;
        cof_row = 2'd0;
      end
      ST_MUL: begin
        // the scaled cofactors are read transposed: adjugate
        cof_row = j_r;
        cof_col = i_r;
      end
      default: begin
      end
    endcase
  end

  assign key_a = key_f(key_row_first_r, key_row_second_r, key_row_third_r, n3,
                       ka_row, ka_col);
  assign key_b = key_f(key_row_first_r, key_row_second_r, key_row_third_r, n3,
                       kb_row, kb_col);
  assign cof_addr = 4'(cof_row) * 4'd3 + 4'(cof_col);
  assign cof_rd   = cof_r[cof_addr];
  assign blk_rd   = blk_r[j_r];

  // MAC control and operand select
  always_comb begin
    mac_ctl = '0;
    op_a    = 5'd0;
    op_b    = 5'd0;
    unique case (state_r)
      ST_COF: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.first = !s_r;
        mac_ctl.bias  = 1'b1;
        mac_ctl.sub   = s_r;
        op_a          = key_a;
        op_b          = key_b;
      end
      ST_DET: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.first = (j_r == 2'd0);
        op_a          = key_a;
        op_b          = cof_rd;
      end
      ST_SCL: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.first = 1'b1;
        op_a          = cof_rd;
        op_b          = dinv_r;
      end
      ST_MUL: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.first = (j_r == 2'd0);
        op_a          = decrypt_r ? cof_rd : key_a;
        op_b          = blk_rd;
      end
      default: begin
      end
    endcase
  end

  hcb_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .res  (mac_res)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    s_nxt     = s_r;
    out_ld    = 1'b0;
    ld_letter = 7'd0;
    ld_last   = 1'b0;
    ld_err    = 1'b0;
    cof_we    = 1'b0;
    dinv_we   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (blk_full) begin
            fill_nxt  = 2'd0;
            i_nxt     = 2'd0;
            j_nxt     = 2'd0;
            s_nxt     = 1'b0;
            state_nxt = decrypt_r ? ST_COF : ST_MUL;
          end else begin
            fill_nxt = fill_inc;
          end
        end
      end
      ST_COF: begin
        s_nxt = !s_r;
        if (s_r) begin
          state_nxt = ST_CRED;
        end
      end
      ST_CRED: begin
        cof_we = 1'b1;
        if (j_r == 2'd2) begin
          j_nxt = 2'd0;
          if (i_r == 2'd2) begin
            i_nxt     = 2'd0;
            state_nxt = ST_DET;
          end else begin
            i_nxt     = i_r + 2'd1;
            state_nxt = ST_COF;
          end
        end else begin
          j_nxt     = j_r + 2'd1;
          state_nxt = ST_COF;
        end
      end
      ST_DET: begin
        if (j_r == 2'd2) begin
          j_nxt     = 2'd0;
          state_nxt = ST_DRED;
        end else begin
          j_nxt = j_r + 2'd1;
        end
      end
      ST_DRED: begin
        dinv_we   = 1'b1;
        state_nxt = (inv26_f(mac_res) == 5'd0) ? ST_ERR : ST_SCL;
      end
      ST_SCL: begin
        state_nxt = ST_SRED;
      end
      ST_SRED: begin
        cof_we = 1'b1;
        if (j_r == 2'd2) begin
          j_nxt = 2'd0;
          if (i_r == 2'd2) begin
            i_nxt     = 2'd0;
            state_nxt = ST_MUL;
          end else begin
            i_nxt     = i_r + 2'd1;
            state_nxt = ST_SCL;
          end
        end else begin
          j_nxt     = j_r + 2'd1;
          state_nxt = ST_SCL;
        end
      end
      ST_MUL: begin
        if (j_r == last_idx) begin
          state_nxt = ST_MRED;
        end else begin
          j_nxt = j_r + 2'd1;
        end
      end
      ST_MRED: begin
        if (out_free) begin
          out_ld    = 1'b1;
          ld_letter = 7'(LETTER_A) + {2'd0, mac_res};
          ld_last   = (i_r == last_idx);
          if (i_r == last_idx) begin
            state_nxt = ST_IDLE;
          end else begin
            i_nxt     = i_r + 2'd1;
            j_nxt     = 2'd0;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_ld    = 1'b1;
          ld_last   = 1'b1;
          ld_err    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      fill_r           <= 2'd0;
      i_r              <= 2'd0;
      j_r              <= 2'd0;
      s_r              <= 1'b0;
      out_valid_r      <= 1'b0;
      key_size_r       <= 2'd2;
      decrypt_r        <= 1'b0;
      key_row_first_r  <= 15'd0;
      key_row_second_r <= 15'd0;
      key_row_third_r  <= 15'd0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      s_r         <= s_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY_SIZE:  key_size_r       <= cfg_wdata[1:0];
          CFG_DECRYPT:   decrypt_r        <= cfg_wdata[0];
          CFG_ROW_FIRST: key_row_first_r  <= cfg_wdata;
          CFG_ROW_SEC:   key_row_second_r <= cfg_wdata;
          CFG_ROW_THIRD: key_row_third_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      blk_r[fill_r] <= residue;
    end
    if (cof_we) begin
      cof_r[cof_addr] <= mac_res;
    end
    if (dinv_we) begin
      dinv_r <= inv26_f(mac_res);
    end
    if (out_ld) begin
      out_letter_r <= ld_letter;
      out_last_r   <= ld_last;
      out_err_r    <= ld_err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_letter_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

`ifndef NO_ASSERTIONS
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != 2'd3)
    else $error("block fill count out of range");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == 8'd0)
    else $error("key error result must be a lone last item with zero letter");

  a_busy_after_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && blk_full |=> !in_tready)
    else $error("input accepted while a full block is being processed");

  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata >= 8'd65 && out_tdata <= 8'd90)
    else $error("output letter outside A..Z");
`endif

endmodule

### src/hcb_mac.sv
// Shared multiply-accumulate unit of the Hill cipher block, with a mod-26
// reduction of the registered sum.
// Depends on hcb_pkg.
module hcb_mac (
  input  logic             clk,
  input  hcb_pkg::mac_ctl_t ctl,
  input  logic [4:0]       op_a,
  input  logic [4:0]       op_b,
  output logic [4:0]       res
);
  import hcb_pkg::*;

  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic [ACC_W-1:0] acc_base;
  logic [9:0]       prod;

  assign prod     = op_a * op_b;
  assign acc_base = ctl.first ? (ctl.bias ? COF_BIAS : '0) : acc_r;
  assign acc_nxt  = ctl.sub ? acc_base - ACC_W'(prod) : acc_base + ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign res = mod26_f(acc_r);

endmodule

### test/tb_hill_cipher_block.sv
// Self-checking testbench for hill_cipher_block: text bytes stream in, enciphered
// or deciphered letters are checked against an in-bench mod-26 Hill cipher predictor.
// Depends on src/hcb_pkg.sv and src/hill_cipher_block.sv.
module tb_hill_cipher_block;
  import hcb_pkg::*;

  localparam logic [2:0] REG_KEY_SIZE = 3'd0;
  localparam logic [2:0] REG_DECRYPT  = 3'd1;
  localparam logic [2:0] REG_ROW0     = 3'd2;
  localparam logic [2:0] REG_ROW1     = 3'd3;
  localparam logic [2:0] REG_ROW2     = 3'd4;

  localparam int SETTLE_CYCLES = 80;  // longer than a full decrypt block
  localparam int LONG_HOLD     = 400;

  typedef int mat_t [3][3];

  typedef struct packed {
    logic [6:0] letter;
    logic       last;
    logic       key_err;
  } letter_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [14:0] cfg_wdata = 15'd0;

  // cipher state as the block should hold it
  logic [1:0]  key_size = 2'd2;
  logic        decrypt = 1'b0;
  logic [14:0] key_rows [3] = '{15'd0, 15'd0, 15'd0};
  int          text_buf [3] = '{0, 0, 0};
  logic [1:0]  fill = 2'd0;

  logic [7:0]  text_q [$];
  letter_rec_t letters_due [$];

  logic in_taken = 1'b0;
  logic steady = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  int fail_count = 0;
  int miss_count = 0;
  int bytes_in = 0;
  int blocks_done = 0;
  int key_rejects = 0;
  int letters_seen = 0;

  hill_cipher_block u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int wrap26(input int x);
    int r;
    r = x % 26;
    return (r < 0) ? r + 26 : r;
  endfunction

  function automatic logic [14:0] row3(input int a, input int b, input int c);
    return {5'(c), 5'(b), 5'(a)};
  endfunction

  function automatic int inv_mod26(input int d);
    for (int i = 1; i < 26; i++) begin
      if ((d * i) % 26 == 1) return i;
    end
    return 0;
  endfunction

  function automatic void unpack_key(input logic [14:0] r0, input logic [14:0] r1,
                                     input logic [14:0] r2, output mat_t k);
    logic [14:0] rows [3];
    rows = '{r0, r1, r2};
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        k[r][c] = int'(rows[r][5*c +: 5]) % 26;
      end
    end
  endfunction

  // adjugate and determinant, both unreduced
  function automatic void adjugate(input mat_t k, input int n, output mat_t a, output int det);
    a = '{default: 0};
    if (n == 2) begin
      a[0][0] = k[1][1];  a[0][1] = -k[0][1];
      a[1][0] = -k[1][0]; a[1][1] = k[0][0];
      det = k[0][0] * k[1][1] - k[0][1] * k[1][0];
    end else begin
      det = 0;
      // cyclic index form carries the cofactor sign by itself
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          a[j][i] = k[(i+1)%3][(j+1)%3] * k[(i+2)%3][(j+2)%3]
                  - k[(i+1)%3][(j+2)%3] * k[(i+2)%3][(j+1)%3];
        end
      end
      for (int j = 0; j < 3; j++) det += k[0][j] * a[j][0];
    end
  endfunction

  function automatic bit key_invertible(input int n, input logic [14:0] r0,
                                        input logic [14:0] r1, input logic [14:0] r2);
    mat_t k, a;
    int   det;
    unpack_key(r0, r1, r2, k);
    adjugate(k, n, a, det);
    return inv_mod26(wrap26(det)) != 0;
  endfunction

  // one accepted text byte; queues the letters of a completed block
  task automatic cipher_byte(input logic [7:0] b);
    mat_t        k, a;
    int          n, det, dinv, acc;
    letter_rec_t rec;
    n = (key_size < 2) ? 2 : int'(key_size);
    text_buf[fill % 3] = wrap26(int'(b) - LETTER_A);
    fill = fill + 2'd1;
    if (fill < n) return;
    fill = 2'd0;
    blocks_done++;
    unpack_key(key_rows[0], key_rows[1], key_rows[2], k);
    if (decrypt) begin
      adjugate(k, n, a, det);
      dinv = inv_mod26(wrap26(det));
      if (dinv == 0) begin
        rec = '{letter: 7'd0, last: 1'b1, key_err: 1'b1};
        letters_due.push_back(rec);
        key_rejects++;
        return;
      end
      for (int r = 0; r < n; r++) begin
        for (int c = 0; c < n; c++) k[r][c] = wrap26(wrap26(a[r][c]) * dinv);
      end
    end
    for (int r = 0; r < n; r++) begin
      acc = 0;
      for (int c = 0; c < n; c++) acc += k[r][c] * text_buf[c];
      rec = '{letter: 7'(LETTER_A + wrap26(acc)), last: (r == n - 1), key_err: 1'b0};
      letters_due.push_back(rec);
    end
  endtask

  task automatic note_miss(input string what, input letter_rec_t want);
    fail_count++;
    miss_count++;
    if (miss_count <= 10) begin
      $display("[%0t] %s: expected letter %0d last %0b err %0b, got tdata %0d last %0b err %0b",
               $realtime, what, want.letter, want.last, want.key_err,
               out_tdata, out_tlast, out_tuser);
    end
  endtask

  // sender: keeps a request up until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (text_q.size() != 0 && (steady || $urandom_range(99) >= 10)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= text_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= LONG_HOLD;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= steady || $urandom_range(99) >= 10;
    end
  end

  always @(posedge clk) begin
    letter_rec_t want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        cipher_byte(in_tdata);
        bytes_in++;
      end
      if (out_tvalid && out_tready) begin
        letters_seen++;
        if (letters_due.size() == 0) begin
          note_miss("unexpected result", '0);
        end else begin
          want = letters_due.pop_front();
          if (out_tdata != {1'b0, want.letter} || out_tlast != want.last ||
              out_tuser != want.key_err) begin
            note_miss("result mismatch", want);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [14:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_KEY_SIZE: key_size = val[1:0];
      REG_DECRYPT:  decrypt = val[0];
      REG_ROW0:     key_rows[0] = val;
      REG_ROW1:     key_rows[1] = val;
      REG_ROW2:     key_rows[2] = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_key(input logic [1:0] sz, input logic dec, input logic [14:0] r0,
                          input logic [14:0] r1, input logic [14:0] r2);
    write_reg(REG_KEY_SIZE, 15'(sz));
    write_reg(REG_DECRYPT, 15'(dec));
    write_reg(REG_ROW0, r0);
    write_reg(REG_ROW1, r1);
    write_reg(REG_ROW2, r2);
  endtask

  // all requests taken, all letters back, and the block given time to go idle
  task automatic settle();
    do @(negedge clk);
    while (text_q.size() != 0 || in_tvalid || letters_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_bytes(input logic [7:0] bytes [$]);
    @(posedge clk);
    foreach (bytes[i]) text_q.push_back(bytes[i]);
  endtask

  task automatic send_random(input int count);
    @(posedge clk);
    repeat (count) begin
      if ($urandom_range(99) < 85) text_q.push_back(8'($urandom_range(65, 90)));
      else text_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [1:0]  sz;
    logic        dec;
    logic [14:0] r0, r1, r2;
    int          n, tries, count;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset config: size 2, encrypt, all-zero key
    send_bytes('{8'd0, 8'd255});
    settle();
    // unused key fields at 31 must not matter at size 2
    load_key(2'd2, 1'b0, row3(3, 3, 31), row3(2, 5, 31), 15'h7FFF);
    send_bytes('{8'd65, 8'd90});
    settle();
    // all fields 31 reduce to 5: a singular key, encrypt still emits letters
    load_key(2'd3, 1'b0, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    send_bytes('{8'd64, 8'd91, 8'd128});
    settle();
    load_key(2'd2, 1'b1, row3(3, 3, 0), row3(2, 5, 0), 15'd0);
    send_bytes('{8'd72, 8'd73});
    settle();
    load_key(2'd3, 1'b1, row3(6, 24, 1), row3(13, 16, 10), row3(20, 17, 15));
    send_bytes('{8'd80, 8'd79, 8'd72});
    settle();
    // keys with no inverse mod 26
    load_key(2'd2, 1'b1, row3(2, 4, 0), row3(6, 8, 0), 15'd0);
    send_bytes('{8'd66, 8'd67});
    settle();
    load_key(2'd3, 1'b1, 15'd0, 15'd0, 15'd0);
    send_bytes('{8'd68, 8'd69, 8'd70});
    settle();
    // sizes below two behave as two
    load_key(2'd0, 1'b0, row3(1, 2, 0), row3(3, 4, 0), 15'd0);
    send_bytes('{8'd75, 8'd76});
    settle();
    write_reg(REG_KEY_SIZE, 15'd1);
    send_bytes('{8'd77, 8'd78});
    settle();
    // shrink the size with two letters held: the third completes the block
    load_key(2'd3, 1'b0, row3(5, 7, 9), row3(11, 13, 15), row3(17, 19, 21));
    send_bytes('{8'd81, 8'd82});
    settle();
    write_reg(REG_KEY_SIZE, 15'd2);
    send_bytes('{8'd83});
    settle();
    // grow the size with one letter held
    send_bytes('{8'd84});
    settle();
    write_reg(REG_KEY_SIZE, 15'd3);
    send_bytes('{8'd85, 8'd86});
    settle();

    for (int ph = 0; ph < 14; ph++) begin
      settle();
      tries = $urandom_range(9);
      sz  = (tries < 4) ? 2'd2 : (tries < 8) ? 2'd3 : 2'(tries - 8);
      dec = (ph == 6) ? 1'b0 : 1'($urandom_range(1));
      n   = (sz < 2) ? 2 : int'(sz);
      r0 = 15'($urandom);
      r1 = 15'($urandom);
      r2 = 15'($urandom);
      // most decrypt phases get a usable key
      if (dec && $urandom_range(3) != 0) begin
        tries = 0;
        while (!key_invertible(n, r0, r1, r2) && tries < 200) begin
          r0 = 15'($urandom);
          r1 = 15'($urandom);
          r2 = 15'($urandom);
          tries++;
        end
      end
      load_key(sz, dec, r0, r1, r2);
      steady   <= (ph == 3);
      count = $urandom_range(4, 9) * n;
      if ($urandom_range(3) == 0) count += $urandom_range(1, n - 1);
      if (ph == 6) begin
        // receiver holds off while the sender keeps offering
        hold_req <= 1'b1;
        count = 36;
      end
      send_random(count);
    end
    settle();

    $display("Covered %0d text bytes in %0d blocks, %0d refused for a key with no inverse,",
             bytes_in, blocks_done, key_rejects);
    $display("%0d results checked over key sizes 0..3, both modes, mid-block size changes.",
             letters_seen);
    if (fail_count == 0) begin
      $display("PASS hill_cipher_block");
    end else begin
      $display("FAIL hill_cipher_block");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL hill_cipher_block");
    $finish;
  end

endmodule
